/* rtl/bfd_pkg.sv */
`default_nettype none

package bfd_pkg;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int HDR_BYTES = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN_MODE_AC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_SHORT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_LONG    = 2'd2;

    localparam logic [7:0] ESC_BYTE     = 8'h1a;
    localparam logic [7:0] TYPE_MODE_AC = 8'h31;
    localparam logic [7:0] TYPE_LONG    = 8'h33;

    localparam logic [1:0] ST_FRAME    = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_LONE_ESC = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  frame_kind;
        logic [47:0] timestamp;
        logic [7:0]  signal_level;
        logic [63:0] payload_first;
        logic [47:0] payload_rest;
    } result_t;

endpackage

`default_nettype wire

/* rtl/bfd_parse.sv */
`default_nettype none

module bfd_parse import bfd_pkg::*; #(
    parameter int MAX_PAYLOAD = 14
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 in_fire,
    input  wire logic [7:0]           in_byte,
    output logic                      res_valid,
    output result_t                   res
);

    localparam int CNT_W = $clog2(HDR_BYTES + MAX_PAYLOAD + 1);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [CFG_W-1:0] len_mode_ac_reg, len_short_reg, len_long_reg;

    logic [1:0]       phase_reg, phase_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       kind_reg, kind_next;
    logic [47:0]      time_reg, time_next;
    logic [7:0]       signal_reg, signal_next;
    logic [MAX_PAYLOAD-1:0][7:0] pl_reg, pl_next;

    logic [CFG_W-1:0] len_raw;
    logic [CNT_W-1:0] len_sat;
    logic             known_type;
    logic             do_start;
    logic             do_take;
    logic [63:0]      first_w;
    logic [47:0]      rest_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_mode_ac_reg <= CFG_W'(2);
            len_short_reg   <= CFG_W'(7);
            len_long_reg    <= CFG_W'(14);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEN_MODE_AC: len_mode_ac_reg <= cfg_wdata;
                CFG_LEN_SHORT:   len_short_reg   <= cfg_wdata;
                CFG_LEN_LONG:    len_long_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (kind_reg)
            2'd0:    len_raw = len_mode_ac_reg;
            2'd1:    len_raw = len_short_reg;
            default: len_raw = len_long_reg;
        endcase
        if (32'(len_raw) > MAX_PAYLOAD) begin
            len_sat = CNT_W'(MAX_PAYLOAD);
        end else begin
            len_sat = CNT_W'(len_raw);
        end
    end

    assign known_type = (in_byte >= TYPE_MODE_AC) && (in_byte <= TYPE_LONG);

    always_comb begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        time_next   = time_reg;
        signal_next = signal_reg;
        pl_next     = pl_reg;
        do_start    = 1'b0;
        do_take     = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        first_w     = '0;
        rest_w      = '0;

        if (in_fire) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (in_byte == ESC_BYTE) begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (known_type) begin
                        do_start = 1'b1;
                    end else begin
                        phase_next = PH_HUNT;
                        res_valid  = 1'b1;
                        res.status = ST_UNKNOWN;
                    end
                end
                PH_BODY: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        if (in_byte != ESC_BYTE) begin
                            res_valid  = 1'b1;
                            res.status = ST_LONE_ESC;
                            if (known_type) begin
                                do_start = 1'b1;
                            end else begin
                                phase_next = PH_HUNT;
                            end
                        end else begin
                            do_take = 1'b1;
                        end
                    end else if (in_byte == ESC_BYTE) begin
                        esc_next = 1'b1;
                    end else begin
                        do_take = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        if (do_start) begin
            kind_next   = 2'(in_byte - TYPE_MODE_AC);
            count_next  = '0;
            esc_next    = 1'b0;
            time_next   = '0;
            signal_next = '0;
            pl_next     = '0;
            phase_next  = PH_BODY;
        end

        if (do_take) begin
            if (count_reg < CNT_W'(6)) begin
                time_next = {time_reg[39:0], in_byte};
            end else if (count_reg == CNT_W'(6)) begin
                signal_next = in_byte;
            end
            for (int i = 0; i < MAX_PAYLOAD; i++) begin
                if (count_reg == CNT_W'(HDR_BYTES + i)) begin
                    pl_next[i] = in_byte;
                end
            end
            // payload packing, byte 0 at the top of the first word
            for (int i = 0; i < 8 && i < MAX_PAYLOAD; i++) begin
                first_w[63-8*i -: 8] = pl_next[i];
            end
            for (int i = 8; i < MAX_PAYLOAD; i++) begin
                rest_w[47-8*(i-8) -: 8] = pl_next[i];
            end
            count_next = count_reg + CNT_W'(1);
            if (count_next >= CNT_W'(HDR_BYTES) + len_sat) begin
                phase_next        = PH_HUNT;
                res_valid         = 1'b1;
                res.status        = ST_FRAME;
                res.frame_kind    = kind_reg;
                res.timestamp     = time_next;
                res.signal_level  = signal_next;
                res.payload_first = first_w;
                res.payload_rest  = rest_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
            kind_reg   <= '0;
            time_reg   <= '0;
            signal_reg <= '0;
            pl_reg     <= '0;
        end else begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
            time_reg   <= time_next;
            signal_reg <= signal_next;
            pl_reg     <= pl_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (count_reg < CNT_W'(HDR_BYTES + MAX_PAYLOAD)))
        else $error("body count past the longest frame");
    a_esc_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (phase_reg == PH_BODY))
        else $error("escape pending outside a frame body");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status != ST_FRAME)) |->
        (res.frame_kind == 2'd0 && res.timestamp == 48'd0 && res.signal_level == 8'd0
         && res.payload_first == 64'd0 && res.payload_rest == 48'd0))
        else $error("error item carries frame fields");
`endif

endmodule

`default_nettype wire

/* rtl/bfd_outbuf.sv */
`default_nettype none

module bfd_outbuf import bfd_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    input  wire result_t in_res,
    output logic         in_ready,
    output logic         out_valid,
    output result_t      out_res,
    input  wire logic    out_ready
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_res_reg, out_res_next;
    result_t skid_res_reg, skid_res_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output is empty");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !in_valid)
        else $error("item arrived with the skid full");
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready && in_valid) |=> skid_valid_reg)
        else $error("item lost on a stalled output");
`endif

endmodule

`default_nettype wire

/* rtl/beast_frame_deframer.sv */
`default_nettype none

// Beast binary stream deframer: takes one raw byte per item on s_ and gives
// one item on m_ per completed frame (tuser status 0), unknown type byte
// (status 1) or lone 0x1a inside a frame body (status 2). A byte is taken
// in every cycle with s_tvalid and s_tready high; the parser handles each
// byte combinationally and its item is registered in the output buffer
// before it shows on m_. A two-entry output buffer lets input continue
// while one item waits on m_tready; s_tready drops only when both entries
// are full. Payload lengths per frame kind come from the three length
// registers, saturated at MAX_PAYLOAD; write them while the stream is quiet.
module beast_frame_deframer import bfd_pkg::*; #(
    parameter int MAX_PAYLOAD = 14
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // frame_kind, timestamp, signal_level, payload_first, payload_rest, zero pad
    output logic [175:0]              m_tdata,
    output logic [1:0]                m_tuser    // status
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    bfd_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    bfd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {6'd0, out_res.payload_rest, out_res.payload_first,
                      out_res.signal_level, out_res.timestamp, out_res.frame_kind};

endmodule

`default_nettype wire
